@@ hdl/fric_pkg.sv @@
`timescale 1ns / 1ps

package fric_pkg;

    localparam int DEPTH_DEF   = 16;
    localparam int KIND_W      = 2;
    localparam int KEY_W       = 32;
    localparam int HANDLE_W    = 32;
    localparam int MAXE_W      = 5;
    localparam int COUNT_OUT_W = 5;
    localparam int MAXE_RESET  = 16;

    // stored word: {last, first, id}
    localparam int WORD_W      = KEY_W + 2 * HANDLE_W;

    // s_axis_tdata: key, payload_first, payload_last -> 96 bits
    localparam int S_TDATA_W   = KEY_W + 2 * HANDLE_W;
    // m_axis_tdata: found_first, found_last, entry_count -> 69 bits, padded to 72
    localparam int M_TDATA_W   = ((2 * HANDLE_W + COUNT_OUT_W + 7) / 8) * 8;

    typedef enum logic [KIND_W-1:0] {
        KIND_ADD    = 2'd0,
        KIND_LOOKUP = 2'd1,
        KIND_FLUSH  = 2'd2
    } kind_t;

    // slot index width, at least one bit
    function automatic int slot_width(input int depth);
        int w;
        w = $clog2(depth);
        return (w < 1) ? 1 : w;
    endfunction

endpackage

@@ hdl/fifo_replacement_id_cache.sv @@
`timescale 1ns / 1ps

// FIFO-replacement id cache. Holds up to max_entries (id, first, last) entries in
// insertion order in a ring of DEPTH slots kept in a single-port-read RAM. Each
// input transfer gives exactly one output transfer. An add stores the entry as the
// newest, evicting the oldest once max_entries are held; a flush empties the cache;
// a lookup reads the RAM one slot per cycle from newest to oldest and stops at the
// first id match. Add, flush, unused kinds and a lookup of an empty cache go from the
// input transfer to ST_FINISH, which waits for the output register to be free, loads
// it and raises m_axis_tvalid; a lookup that examines n entries (at most DEPTH) first
// reads them in ST_SCAN, the RAM read port giving one entry per cycle. One item is in
// work at a time; the next input transfer is taken as soon as the current item has
// finished, even while its result waits in the output register. max_entries of 0
// acts as 1, values above DEPTH act as DEPTH; lowering it below the current count
// takes effect at the next add.
module fifo_replacement_id_cache
    import fric_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [MAXE_W-1:0]      cfg_wr_data,    // max_entries
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [S_TDATA_W-1:0]   s_axis_tdata,   // [31:0] key, [63:32] payload_first,
                                                   // [95:64] payload_last
    input  logic [KIND_W-1:0]      s_axis_tuser,   // [1:0] kind
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [M_TDATA_W-1:0]   m_axis_tdata,   // [31:0] found_first, [63:32] found_last,
                                                   // [68:64] entry_count, rest zero
    output logic                   m_axis_tuser    // [0] hit
);

    localparam int SLOT_W = slot_width(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CMP_W  = (CNT_W > MAXE_W) ? CNT_W : MAXE_W;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(DEPTH - 1);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    state_t              state_reg, state_next;
    logic [SLOT_W-1:0]   newest_reg, newest_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [MAXE_W-1:0]   maxe_reg;
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic [SLOT_W-1:0]   scan_slot_reg, scan_slot_next;
    logic [KEY_W-1:0]    key_reg, key_next;

    logic                res_hit_reg, res_hit_next;
    logic [HANDLE_W-1:0] res_first_reg, res_first_next;
    logic [HANDLE_W-1:0] res_last_reg, res_last_next;

    logic                m_valid_reg, m_valid_next;
    logic                m_hit_reg, m_hit_next;
    logic [HANDLE_W-1:0] m_first_reg, m_first_next;
    logic [HANDLE_W-1:0] m_last_reg, m_last_next;
    logic [COUNT_OUT_W-1:0] m_cnt_reg, m_cnt_next;

    logic                accept;
    logic                out_free;
    logic [KIND_W-1:0]   in_kind;
    logic [KEY_W-1:0]    in_key;
    logic [HANDLE_W-1:0] in_first;
    logic [HANDLE_W-1:0] in_last;

    logic [CMP_W-1:0]    maxe_ext;
    logic [CNT_W-1:0]    cap;
    logic [CMP_W-1:0]    count_ext;
    logic [SLOT_W-1:0]   newest_inc;
    logic [SLOT_W-1:0]   scan_dec;

    logic                wr_en;
    logic [WORD_W-1:0]   wr_data;
    logic                rd_en;
    logic [SLOT_W-1:0]   rd_addr;
    logic [WORD_W-1:0]   rd_data;
    logic [KEY_W-1:0]    rd_id;
    logic [HANDLE_W-1:0] rd_first;
    logic [HANDLE_W-1:0] rd_last;

    assign in_key   = s_axis_tdata[KEY_W-1:0];
    assign in_first = s_axis_tdata[KEY_W +: HANDLE_W];
    assign in_last  = s_axis_tdata[KEY_W + HANDLE_W +: HANDLE_W];
    assign in_kind  = s_axis_tuser;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid & s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;

    // effective capacity: 0 -> 1, above DEPTH -> DEPTH
    assign maxe_ext = CMP_W'(maxe_reg);
    always_comb begin
        if (maxe_reg == '0) begin
            cap = CNT_W'(1);
        end else if (maxe_ext > CMP_W'(DEPTH)) begin
            cap = CNT_W'(DEPTH);
        end else begin
            cap = maxe_ext[CNT_W-1:0];
        end
    end

    assign count_ext  = CMP_W'(count_reg);
    assign newest_inc = (newest_reg == LAST_SLOT) ? '0 : newest_reg + SLOT_W'(1);
    assign scan_dec   = (scan_slot_reg == '0) ? LAST_SLOT : scan_slot_reg - SLOT_W'(1);

    assign wr_en   = accept && (in_kind == KIND_ADD);
    assign wr_data = {in_last, in_first, in_key};

    assign rd_id    = rd_data[KEY_W-1:0];
    assign rd_first = rd_data[KEY_W +: HANDLE_W];
    assign rd_last  = rd_data[KEY_W + HANDLE_W +: HANDLE_W];

    // reads never overlap the add's write: one item in work at a time
    fric_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (newest_inc),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb begin
        state_next     = state_reg;
        newest_next    = newest_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        scan_slot_next = scan_slot_reg;
        key_next       = key_reg;
        res_hit_next   = res_hit_reg;
        res_first_next = res_first_reg;
        res_last_next  = res_last_reg;
        rd_en          = 1'b0;
        rd_addr        = newest_reg;

        m_valid_next = m_axis_tready ? 1'b0 : m_valid_reg;
        m_hit_next   = m_hit_reg;
        m_first_next = m_first_reg;
        m_last_next  = m_last_reg;
        m_cnt_next   = m_cnt_reg;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    res_hit_next   = 1'b0;
                    res_first_next = '0;
                    res_last_next  = '0;
                    state_next     = ST_FINISH;
                    case (in_kind)
                        KIND_ADD: begin
                            newest_next = newest_inc;
                            count_next  = (count_reg < cap) ? count_reg + CNT_W'(1) : cap;
                        end
                        KIND_LOOKUP: begin
                            key_next = in_key;
                            if (count_reg != '0) begin
                                rd_en          = 1'b1;
                                rd_addr        = newest_reg;
                                scan_slot_next = newest_reg;
                                idx_next       = '0;
                                state_next     = ST_SCAN;
                            end
                        end
                        KIND_FLUSH: begin
                            count_next  = '0;
                            newest_next = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                // rd_data holds the slot at scan_slot_reg
                if (rd_id == key_reg) begin
                    res_hit_next   = 1'b1;
                    res_first_next = rd_first;
                    res_last_next  = rd_last;
                    state_next     = ST_FINISH;
                end else if (idx_reg + CNT_W'(1) == count_reg) begin
                    state_next = ST_FINISH;
                end else begin
                    rd_en          = 1'b1;
                    rd_addr        = scan_dec;
                    scan_slot_next = scan_dec;
                    idx_next       = idx_reg + CNT_W'(1);
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_hit_next   = res_hit_reg;
                    m_first_next = res_first_reg;
                    m_last_next  = res_last_reg;
                    m_cnt_next   = count_ext[COUNT_OUT_W-1:0];
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            newest_reg  <= '0;
            count_reg   <= '0;
            maxe_reg    <= MAXE_W'(MAXE_RESET);
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            newest_reg  <= newest_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                maxe_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg       <= idx_next;
        scan_slot_reg <= scan_slot_next;
        key_reg       <= key_next;
        res_hit_reg   <= res_hit_next;
        res_first_reg <= res_first_next;
        res_last_reg  <= res_last_next;
        m_hit_reg     <= m_hit_next;
        m_first_reg   <= m_first_next;
        m_last_reg    <= m_last_next;
        m_cnt_reg     <= m_cnt_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = m_hit_reg;
    assign m_axis_tdata  = M_TDATA_W'({m_cnt_reg, m_last_reg, m_first_reg});

endmodule

@@ hdl/fric_store.sv @@
`timescale 1ns / 1ps

module fric_store
    import fric_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                         aclk,
    input  logic                         wr_en,
    input  logic [slot_width(DEPTH)-1:0] wr_addr,
    input  logic [WORD_W-1:0]            wr_data,
    input  logic                         rd_en,
    input  logic [slot_width(DEPTH)-1:0] rd_addr,
    output logic [WORD_W-1:0]            rd_data
);

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hdl/fric_checker.sv @@
`timescale 1ns / 1ps

module fric_checker
    import fric_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata,
    input logic                 m_axis_tuser
);

    localparam int CNT_LSB = 2 * HANDLE_W;

    // no result is pending right after reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // one item in work: input closes after each transfer
    a_one_in_work: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready right after a transfer");

    // stalled result transfer holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // a miss carries zero handles
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[CNT_LSB-1:0] == '0)
        else $error("handles nonzero without hit");

    // reported count never exceeds the ring size
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |->
            (DEPTH >= 32) || (m_axis_tdata[CNT_LSB +: COUNT_OUT_W] <= COUNT_OUT_W'(DEPTH)))
        else $error("entry count above depth");

endmodule

bind fifo_replacement_id_cache fric_checker #(.DEPTH(DEPTH)) u_fric_checker (.*);

@@ verif/fifo_replacement_id_cache_test.sv @@
`timescale 1ns / 1ps

module fifo_replacement_id_cache_test;
    import fric_pkg::*;

    localparam int                CLK_HALF    = 4;
    localparam int                SLOTS       = DEPTH_DEF;
    localparam int                SETTLE_CYC  = 24;     // longer than a full-depth lookup
    localparam int                STALL_LIMIT = 4000;
    localparam int                PHASE_ITEMS = 172;
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    typedef struct packed {
        logic                   hit;
        logic [HANDLE_W-1:0]    first;
        logic [HANDLE_W-1:0]    last;
        logic [COUNT_OUT_W-1:0] count;
    } lookup_result_t;

    // Tracks cache contents and holds the results still owed by the block.
    class cache_scoreboard;
        logic [KEY_W-1:0]    slot_id[SLOTS];
        logic [HANDLE_W-1:0] slot_first[SLOTS];
        logic [HANDLE_W-1:0] slot_last[SLOTS];
        int unsigned         newest;
        int unsigned         count;
        int unsigned         max_reg;
        lookup_result_t      owed_q[$];
        int                  errors;

        function new();
            newest  = 0;
            count   = 0;
            max_reg = MAXE_RESET;
            errors  = 0;
        endfunction

        function void set_max(input logic [MAXE_W-1:0] value);
            max_reg = value;
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

        function void note_input(input logic [KIND_W-1:0] kind, input logic [KEY_W-1:0] key,
                                 input logic [HANDLE_W-1:0] pfirst,
                                 input logic [HANDLE_W-1:0] plast);
            lookup_result_t r;
            int unsigned    cap;
            int unsigned    s;
            r = '0;
            case (kind)
                KIND_ADD: begin
                    newest             = (newest + 1) % SLOTS;
                    slot_id[newest]    = key;
                    slot_first[newest] = pfirst;
                    slot_last[newest]  = plast;
                    cap = (max_reg == 0) ? 1 : ((max_reg > SLOTS) ? SLOTS : max_reg);
                    // a lowered limit trims the count here, not at the register write
                    if (count < cap) count++;
                    else count = cap;
                end
                KIND_LOOKUP: begin
                    for (int i = 0; i < count; i++) begin
                        s = (newest + SLOTS - i) % SLOTS;
                        if (slot_id[s] == key) begin
                            r.hit   = 1'b1;
                            r.first = slot_first[s];
                            r.last  = slot_last[s];
                            break;
                        end
                    end
                end
                KIND_FLUSH: begin
                    count  = 0;
                    newest = 0;
                end
                default: ;
            endcase
            r.count = count[COUNT_OUT_W-1:0];
            owed_q.push_back(r);
        endfunction

        function void compare_field(input string name, input logic [31:0] exp_v,
                                    input logic [31:0] act_v);
            if (exp_v !== act_v) begin
                errors++;
                $display("%0t ns: %s mismatch, expected %h, actual %h",
                         $time, name, exp_v, act_v);
            end
        endfunction

        function void check_result(input logic hit, input logic [M_TDATA_W-1:0] tdata);
            lookup_result_t exp_r;
            if (owed_q.size() == 0) begin
                errors++;
                $display("%0t ns: unexpected result, expected none, actual hit %0b tdata %h",
                         $time, hit, tdata);
                return;
            end
            exp_r = owed_q.pop_front();
            compare_field("hit", 32'(exp_r.hit), 32'(hit));
            compare_field("found_first", exp_r.first, tdata[31:0]);
            compare_field("found_last", exp_r.last, tdata[63:32]);
            compare_field("entry_count", 32'(exp_r.count), 32'(tdata[68:64]));
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [MAXE_W-1:0]    cfg_wr_data;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata;
    logic [KIND_W-1:0]    s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic                 m_axis_tuser;

    cache_scoreboard sb;
    bit              tx_idle_en;
    bit              rx_idle_en;
    int              stall_cycles;
    logic [KEY_W-1:0] id_pool[8];

    fifo_replacement_id_cache DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #CLK_HALF aclk = ~aclk;
    end

    // transfer monitor and no-progress watchdog
    always @(posedge aclk) begin
        if (aresetn && s_axis_tvalid && s_axis_tready)
            sb.note_input(s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[63:32],
                          s_axis_tdata[95:64]);
        if (aresetn && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tuser, m_axis_tdata);
        if (!aresetn || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t ns: no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // result-side backpressure
    initial begin
        m_axis_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (rx_idle_en && $urandom_range(0, 5) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge aclk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    task automatic send_item(input logic [KIND_W-1:0] kind, input logic [KEY_W-1:0] key,
                             input logic [HANDLE_W-1:0] pfirst,
                             input logic [HANDLE_W-1:0] plast);
        @(negedge aclk);
        if (tx_idle_en && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {plast, pfirst, key};
        s_axis_tuser  <= kind;
        do @(posedge aclk); while (!s_axis_tready);
    endtask

    task automatic drain();
        @(negedge aclk);
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
    endtask

    task automatic write_max(input logic [MAXE_W-1:0] value);
        drain();
        repeat (SETTLE_CYC) @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        sb.set_max(value);
    endtask

    task automatic random_item();
        int unsigned      pick;
        logic [KEY_W-1:0] key;
        logic [KIND_W-1:0] kind;
        pick = $urandom_range(0, 99);
        if (pick < 46) kind = KIND_ADD;
        else if (pick < 95) kind = KIND_LOOKUP;
        else if (pick < 97) kind = KIND_FLUSH;
        else kind = KIND_UNUSED;
        key = ($urandom_range(0, 3) == 0) ? $urandom : id_pool[$urandom_range(0, 7)];
        send_item(kind, key, $urandom, $urandom);
    endtask

    initial begin
        logic [MAXE_W-1:0] phase_max[8];
        sb            = new();
        aresetn       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = KIND_ADD;
        tx_idle_en    = 1'b1;
        rx_idle_en    = 1'b1;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: empty cache, unused kind, extreme values, newest-match, flush
        send_item(KIND_LOOKUP, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(KIND_UNUSED, $urandom, $urandom, $urandom);
        send_item(KIND_ADD, 32'h0, 32'h0, 32'h0);
        send_item(KIND_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(KIND_ADD, 32'h5, 32'hA5A5_0001, 32'h5A5A_0002);
        send_item(KIND_ADD, 32'h5, 32'hC3C3_0003, 32'h3C3C_0004);
        send_item(KIND_LOOKUP, 32'h5, 32'h0, 32'h0);
        send_item(KIND_LOOKUP, 32'h0, 32'h0, 32'h0);
        send_item(KIND_LOOKUP, 32'hFFFF_FFFF, 32'h0, 32'h0);
        send_item(KIND_LOOKUP, 32'h1234_5678, 32'h0, 32'h0);
        send_item(KIND_FLUSH, 32'h5, 32'h0, 32'h0);
        send_item(KIND_LOOKUP, 32'h5, 32'h0, 32'h0);
        send_item(KIND_ADD, 32'h7, 32'h7777_7777, 32'h0);
        send_item(KIND_LOOKUP, 32'h7, 32'h0, 32'h0);

        // limit lowered below the count: old entries stay until the next add
        send_item(KIND_FLUSH, 32'h0, 32'h0, 32'h0);
        for (int i = 0; i < 6; i++)
            send_item(KIND_ADD, 32'h100 + i, $urandom, $urandom);
        write_max(5'd3);
        send_item(KIND_LOOKUP, 32'h100, 32'h0, 32'h0);
        send_item(KIND_ADD, 32'h200, $urandom, $urandom);
        send_item(KIND_LOOKUP, 32'h100, 32'h0, 32'h0);
        send_item(KIND_LOOKUP, 32'h105, 32'h0, 32'h0);
        send_item(KIND_LOOKUP, 32'h103, 32'h0, 32'h0);

        phase_max = '{5'd1, 5'd0, 5'd31, 5'd17, 5'd16, 5'd5, 5'd2, 5'd16};
        phase_max[6] = $urandom_range(2, 15);
        for (int p = 0; p < 8; p++) begin
            write_max(phase_max[p]);
            for (int i = 0; i < 8; i++) id_pool[i] = $urandom;
            id_pool[0] = ($urandom_range(0, 1) == 0) ? 32'h0 : 32'hFFFF_FFFF;
            tx_idle_en = (p < 7) && ($urandom_range(0, 3) != 0);
            rx_idle_en = (p < 7) && ($urandom_range(0, 3) != 0);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (i == PHASE_ITEMS / 2 && (p == 0 || $urandom_range(0, 1) == 0))
                    drain();
                random_item();
            end
        end

        drain();
        repeat (SETTLE_CYC) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("CHECK OK");
        end else begin
            if (sb.pending() != 0)
                $display("%0t ns: %0d results never arrived", $time, sb.pending());
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

@@ files.f @@
hdl/fric_pkg.sv
hdl/fric_store.sv
hdl/fifo_replacement_id_cache.sv
hdl/fric_checker.sv
verif/fifo_replacement_id_cache_test.sv
